>>> rtl/lpj_pkg.sv
// lpj_pkg: widths, constants and payload types shared by the lorentzian peak block.
// Used by every file under rtl; depends on nothing.
package lpj_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // register port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FWHM      = 2'd2;
  localparam logic [WORD_BITS-1:0] AMP_RESET = WORD_BITS'(1) << FRAC_BITS;

  // 1/pi in unsigned q0.32
  localparam int PI_W = 31;
  localparam logic [PI_W-1:0] INV_PI_Q32 = 31'd1367130551;

  // operand widths
  localparam int G_W    = WORD_BITS - 1;
  localparam int UA_W   = WORD_BITS;
  localparam int UD_W   = WORD_BITS + 1;
  localparam int DD_W   = 2 * UD_W;
  localparam int GG_W   = 2 * G_W;
  localparam int PIG_W  = PI_W + G_W;
  localparam int UAPI_W = UA_W + PI_W;
  localparam int D1_W   = DD_W + 3;
  localparam int DL     = (D1_W + 1) / 2;
  localparam int DH     = D1_W - DL;
  localparam int PAG_W  = UAPI_W + G_W;
  localparam int NUM2_W = PAG_W + UD_W;
  localparam int NUM3_W = UAPI_W + D1_W;
  localparam int D1SQ_W = 2 * D1_W;

  // binary scale left after cancelling the q0.32 and q16 factors
  localparam int SH0 = 31 - FRAC_BITS;
  localparam int SH1 = 2 * FRAC_BITS - 31;
  localparam int SH2 = 2 * FRAC_BITS - 28;
  localparam int SH3 = 2 * FRAC_BITS - 31;

  localparam int QDEPTH = 8;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] x_sample;
    logic                        last_in;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] peak_value;
    logic signed [WORD_BITS-1:0] d_amplitude;
    logic signed [WORD_BITS-1:0] d_centre;
    logic signed [WORD_BITS-1:0] d_width;
    logic                        divide_by_zero;
    logic                        last_out;
  } out_t;

  // one classified sample: numerators, denominators and signs
  typedef struct packed {
    logic [PAG_W-1:0]  pag;
    logic [PIG_W-1:0]  pig;
    logic [NUM2_W-1:0] num2;
    logic [NUM3_W-1:0] num3;
    logic [D1_W-1:0]   d1;
    logic [D1SQ_W-1:0] d1sq;
    logic              sa;
    logic              sd;
    logic              eneg;
    logic              dz;
    logic              last;
  } work_t;

endpackage

>>> rtl/lorentzian_peak_and_jacobian.sv
// lorentzian_peak_and_jacobian: top level of the lorentzian peak and jacobian block.
// Depends on lpj_pkg, lpj_front, lpj_queue, lpj_div and lpj_back.
//
// Usage:
//   Registers amplitude (0), peak_centre (1) and full_width_half_max (2) are
//   written through cfg_we/cfg_index/cfg_wdata while no sample is in flight;
//   other indexes are ignored. Reset loads amplitude 1.0, centre 0, width 0.
//   Samples go in as a queue push: a beat is taken when in_push is high and
//   in_full is low. Results come out as a queue pop: out_data holds the oldest
//   result while out_empty is low, and a beat leaves when out_pop is high.
//   One result per sample, in order, with last_out copied from last_in.
//   From input beat to out_empty falling, a sample passes 6 multiply stages,
//   the queue, a 33-stage divider (an input stage, then one quotient bit per
//   stage) and the output register. Throughput is one sample per cycle while
//   out_pop keeps up. If out_pop stays low the divider pipeline holds, the queue
//   between the multiply and divide parts fills, and in_full rises once the
//   queue depth of samples is outstanding in front of it.
//   Reset empties the pipeline and queue; nothing else needs clearing.
module lorentzian_peak_and_jacobian #(
  parameter int QUEUE_DEPTH = lpj_pkg::QDEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpj_pkg::WORD_BITS-1:0]  cfg_wdata,
  input  logic                           in_push,
  input  lpj_pkg::in_t                   in_data,
  output logic                           in_full,
  input  logic                           out_pop,
  output lpj_pkg::out_t                  out_data,
  output logic                           out_empty
);

  logic           wr_valid;
  lpj_pkg::work_t wr_data;
  logic           q_pop;
  logic           q_empty;
  lpj_pkg::work_t q_data;

  lpj_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .q_pop     (q_pop),
    .wr_valid  (wr_valid),
    .wr_data   (wr_data)
  );

  lpj_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_valid),
    .wr_data (wr_data),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  lpj_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

>>> rtl/lpj_div.sv
// lpj_div: pipelined restoring divider, one quotient bit per stage, round and saturate.
// Depends on lpj_pkg for the word width and the default operand widths.
module lpj_div #(
  parameter int NUM_W = lpj_pkg::PAG_W,
  parameter int DEN_W = lpj_pkg::D1_W
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [NUM_W-1:0]               num,
  input  logic [DEN_W-1:0]               den,
  input  logic                           neg,
  output logic [lpj_pkg::WORD_BITS-1:0]  quo
);

  localparam int W  = lpj_pkg::WORD_BITS;
  localparam int VW = DEN_W + 1;
  localparam int CW = (NUM_W + 2 > DEN_W + W + 1) ? NUM_W + 2 : DEN_W + W + 1;

  logic [CW-1:0] rem_r [0:W-1];
  logic [VW-1:0] dv_r  [0:W-1];
  logic [W-1:0]  q_r   [0:W];
  logic          ovf_r [0:W];
  logic          ng_r  [0:W];

  logic [CW-1:0] n2;
  logic [VW-1:0] v2;
  logic [W-1:0]  lim;
  logic [W-1:0]  mag;

  // round to nearest: floor((2n + d) / 2d)
  assign n2 = (CW'(num) << 1) + CW'(den);
  assign v2 = {den, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n2;
      dv_r[0]  <= v2;
      q_r[0]   <= '0;
      ovf_r[0] <= n2 >= (CW'(v2) << W);
      ng_r[0]  <= neg;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= W; k++) begin : g_step
      logic [CW-1:0] trial;
      logic          fits;
      assign trial = CW'(dv_r[k-1]) << (W - k);
      assign fits  = rem_r[k-1] >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          q_r[k]   <= q_r[k-1] | (fits ? (W'(1) << (W - k)) : '0);
          ovf_r[k] <= ovf_r[k-1];
          ng_r[k]  <= ng_r[k-1];
        end
      end
      if (k < W) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[k] <= fits ? rem_r[k-1] - trial : rem_r[k-1];
            dv_r[k]  <= dv_r[k-1];
          end
        end
      end
    end
  endgenerate

  assign lim = ng_r[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
  assign mag = (ovf_r[W] || (q_r[W] > lim)) ? lim : q_r[W];
  assign quo = ng_r[W] ? W'(0) - mag : mag;

endmodule

>>> rtl/lpj_queue.sv
// lpj_queue: small fifo between the front and back parts.
// Depends on lpj_pkg for the work_t entry type.
module lpj_queue #(
  parameter int DEPTH = lpj_pkg::QDEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  lpj_pkg::work_t wr_data,
  input  logic           rd_en,
  output lpj_pkg::work_t rd_data,
  output logic           empty
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lpj_pkg::work_t   mem_r [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rd_ptr_r];
  assign cnt_nxt = cnt_r + CNT_W'(wr_en) - CNT_W'(rd_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r < CNT_W'(DEPTH)) || rd_en)
    else $error("queue written while full");

endmodule

>>> rtl/lpj_front.sv
// lpj_front: config registers, input acceptance with queue credit, and the
// multiply pipeline that forms all numerators and denominators. Depends on lpj_pkg.
module lpj_front #(
  parameter int QUEUE_DEPTH = lpj_pkg::QDEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpj_pkg::WORD_BITS-1:0]  cfg_wdata,
  input  logic                           in_push,
  input  lpj_pkg::in_t                   in_data,
  output logic                           in_full,
  input  logic                           q_pop,
  output logic                           wr_valid,
  output lpj_pkg::work_t                 wr_data
);

  localparam int W      = lpj_pkg::WORD_BITS;
  localparam int G_W    = lpj_pkg::G_W;
  localparam int UA_W   = lpj_pkg::UA_W;
  localparam int UD_W   = lpj_pkg::UD_W;
  localparam int DD_W   = lpj_pkg::DD_W;
  localparam int GG_W   = lpj_pkg::GG_W;
  localparam int PIG_W  = lpj_pkg::PIG_W;
  localparam int UAPI_W = lpj_pkg::UAPI_W;
  localparam int D1_W   = lpj_pkg::D1_W;
  localparam int DL     = lpj_pkg::DL;
  localparam int DH     = lpj_pkg::DH;
  localparam int PAG_W  = lpj_pkg::PAG_W;
  localparam int NUM2_W = lpj_pkg::NUM2_W;
  localparam int NUM3_W = lpj_pkg::NUM3_W;
  localparam int D1SQ_W = lpj_pkg::D1SQ_W;
  localparam int UHI_W  = UAPI_W - W;
  localparam int PLO_W  = W + G_W;
  localparam int PHI_W  = UHI_W + G_W;
  localparam int PTOP_W = PAG_W - 2 * W;
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);

  // configuration
  logic [W-1:0]   amp_r;
  logic [W-1:0]   centre_r;
  logic [G_W-1:0] fwhm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r    <= lpj_pkg::AMP_RESET;
      centre_r <= '0;
      fwhm_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpj_pkg::CFG_AMPLITUDE: amp_r    <= cfg_wdata;
        lpj_pkg::CFG_CENTRE:    centre_r <= cfg_wdata;
        lpj_pkg::CFG_FWHM:      fwhm_r   <= cfg_wdata[G_W-1:0];
        default: ;
      endcase
    end
  end

  // credit: items in this pipeline plus items in the queue
  logic             accept;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  assign in_full = occ_r == OCC_W'(QUEUE_DEPTH);
  assign accept  = in_push && !in_full;
  assign occ_nxt = occ_r + OCC_W'(accept) - OCC_W'(q_pop);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      v1_r  <= accept;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
    end
  end

  // stage 1: offset from centre, magnitudes and signs
  logic [UD_W-1:0] diff;
  logic [UD_W-1:0] diff_abs;
  logic [UA_W-1:0] amp_abs;

  assign diff     = {in_data.x_sample[W-1], in_data.x_sample} - {centre_r[W-1], centre_r};
  assign diff_abs = diff[UD_W-1] ? UD_W'(0) - diff : diff;
  assign amp_abs  = amp_r[W-1] ? UA_W'(0) - amp_r : amp_r;

  logic [UD_W-1:0] ud1_r;
  logic [UA_W-1:0] ua1_r;
  logic [G_W-1:0]  g1_r;
  logic            sa1_r, sd1_r, last1_r;

  // stage 2
  logic [DD_W-1:0]   dd2_r;
  logic [GG_W-1:0]   gg2_r;
  logic [PIG_W-1:0]  pig2_r;
  logic [UAPI_W-1:0] uapi2_r;
  logic [UD_W-1:0]   ud2_r;
  logic [G_W-1:0]    g2_r;
  logic              sa2_r, sd2_r, last2_r;

  // stage 3
  logic [D1_W-1:0]   gg_x;
  logic [D1_W-1:0]   dd_x4;
  logic              e_neg;
  logic [D1_W-1:0]   d1_3_r;
  logic [D1_W-1:0]   e3_r;
  logic [PLO_W-1:0]  pag_lo3_r;
  logic [PHI_W-1:0]  pag_hi3_r;
  logic [UAPI_W-1:0] uapi3_r;
  logic [PIG_W-1:0]  pig3_r;
  logic [UD_W-1:0]   ud3_r;
  logic              sa3_r, sd3_r, eneg3_r, last3_r;

  assign gg_x  = D1_W'(gg2_r);
  assign dd_x4 = D1_W'(dd2_r) << 2;
  assign e_neg = gg_x < dd_x4;

  // stage 4
  logic [PAG_W-1:0]    pag4_r;
  logic [2*DL-1:0]     dll4_r;
  logic [D1_W-1:0]     dlh4_r;
  logic [2*DH-1:0]     dhh4_r;
  logic [W+DL-1:0]     ue00_4_r;
  logic [W+DH-1:0]     ue01_4_r;
  logic [UHI_W+DL-1:0] ue10_4_r;
  logic [UHI_W+DH-1:0] ue11_4_r;
  logic [D1_W-1:0]     d1_4_r;
  logic [PIG_W-1:0]    pig4_r;
  logic [UD_W-1:0]     ud4_r;
  logic                sa4_r, sd4_r, eneg4_r, dz4_r, last4_r;

  // stage 5
  logic [D1SQ_W-1:0]      d1sq5_r;
  logic [NUM3_W-1:0]      num3_5_r;
  logic [W+UD_W-1:0]      c0_5_r;
  logic [W+UD_W-1:0]      c1_5_r;
  logic [PTOP_W+UD_W-1:0] c2_5_r;
  logic [PAG_W-1:0]       pag5_r;
  logic [PIG_W-1:0]       pig5_r;
  logic [D1_W-1:0]        d1_5_r;
  logic                   sa5_r, sd5_r, eneg5_r, dz5_r, last5_r;

  // stage 6
  logic [NUM2_W-1:0] num2_6_r;
  logic [NUM3_W-1:0] num3_6_r;
  logic [D1SQ_W-1:0] d1sq6_r;
  logic [PAG_W-1:0]  pag6_r;
  logic [PIG_W-1:0]  pig6_r;
  logic [D1_W-1:0]   d1_6_r;
  logic              sa6_r, sd6_r, eneg6_r, dz6_r, last6_r;

  always_ff @(posedge clk) begin
    ud1_r   <= diff_abs;
    ua1_r   <= amp_abs;
    g1_r    <= fwhm_r;
    sa1_r   <= amp_r[W-1];
    sd1_r   <= diff[UD_W-1];
    last1_r <= in_data.last_in;

    dd2_r   <= DD_W'(ud1_r) * DD_W'(ud1_r);
    gg2_r   <= GG_W'(g1_r) * GG_W'(g1_r);
    pig2_r  <= PIG_W'(lpj_pkg::INV_PI_Q32) * PIG_W'(g1_r);
    uapi2_r <= UAPI_W'(ua1_r) * UAPI_W'(lpj_pkg::INV_PI_Q32);
    ud2_r   <= ud1_r;
    g2_r    <= g1_r;
    sa2_r   <= sa1_r;
    sd2_r   <= sd1_r;
    last2_r <= last1_r;

    d1_3_r    <= gg_x + dd_x4;
    e3_r      <= e_neg ? dd_x4 - gg_x : gg_x - dd_x4;
    eneg3_r   <= e_neg;
    pag_lo3_r <= PLO_W'(uapi2_r[W-1:0]) * PLO_W'(g2_r);
    pag_hi3_r <= PHI_W'(uapi2_r[UAPI_W-1:W]) * PHI_W'(g2_r);
    uapi3_r   <= uapi2_r;
    pig3_r    <= pig2_r;
    ud3_r     <= ud2_r;
    sa3_r     <= sa2_r;
    sd3_r     <= sd2_r;
    last3_r   <= last2_r;

    // split products of the wide operands
    pag4_r   <= PAG_W'(pag_lo3_r) + (PAG_W'(pag_hi3_r) << W);
    dll4_r   <= (2*DL)'(d1_3_r[DL-1:0]) * (2*DL)'(d1_3_r[DL-1:0]);
    dlh4_r   <= D1_W'(d1_3_r[DL-1:0]) * D1_W'(d1_3_r[D1_W-1:DL]);
    dhh4_r   <= (2*DH)'(d1_3_r[D1_W-1:DL]) * (2*DH)'(d1_3_r[D1_W-1:DL]);
    ue00_4_r <= (W+DL)'(uapi3_r[W-1:0]) * (W+DL)'(e3_r[DL-1:0]);
    ue01_4_r <= (W+DH)'(uapi3_r[W-1:0]) * (W+DH)'(e3_r[D1_W-1:DL]);
    ue10_4_r <= (UHI_W+DL)'(uapi3_r[UAPI_W-1:W]) * (UHI_W+DL)'(e3_r[DL-1:0]);
    ue11_4_r <= (UHI_W+DH)'(uapi3_r[UAPI_W-1:W]) * (UHI_W+DH)'(e3_r[D1_W-1:DL]);
    d1_4_r   <= d1_3_r;
    dz4_r    <= d1_3_r == '0;
    pig4_r   <= pig3_r;
    ud4_r    <= ud3_r;
    sa4_r    <= sa3_r;
    sd4_r    <= sd3_r;
    eneg4_r  <= eneg3_r;
    last4_r  <= last3_r;

    d1sq5_r  <= D1SQ_W'(dll4_r) + (D1SQ_W'(dlh4_r) << (DL + 1))
              + (D1SQ_W'(dhh4_r) << (2 * DL));
    num3_5_r <= NUM3_W'(ue00_4_r) + (NUM3_W'(ue01_4_r) << DL)
              + (NUM3_W'(ue10_4_r) << W) + (NUM3_W'(ue11_4_r) << (W + DL));
    c0_5_r   <= (W+UD_W)'(pag4_r[W-1:0]) * (W+UD_W)'(ud4_r);
    c1_5_r   <= (W+UD_W)'(pag4_r[2*W-1:W]) * (W+UD_W)'(ud4_r);
    c2_5_r   <= (PTOP_W+UD_W)'(pag4_r[PAG_W-1:2*W]) * (PTOP_W+UD_W)'(ud4_r);
    pag5_r   <= pag4_r;
    pig5_r   <= pig4_r;
    d1_5_r   <= d1_4_r;
    sa5_r    <= sa4_r;
    sd5_r    <= sd4_r;
    eneg5_r  <= eneg4_r;
    dz5_r    <= dz4_r;
    last5_r  <= last4_r;

    num2_6_r <= NUM2_W'(c0_5_r) + (NUM2_W'(c1_5_r) << W) + (NUM2_W'(c2_5_r) << (2 * W));
    num3_6_r <= num3_5_r;
    d1sq6_r  <= d1sq5_r;
    pag6_r   <= pag5_r;
    pig6_r   <= pig5_r;
    d1_6_r   <= d1_5_r;
    sa6_r    <= sa5_r;
    sd6_r    <= sd5_r;
    eneg6_r  <= eneg5_r;
    dz6_r    <= dz5_r;
    last6_r  <= last5_r;
  end

  assign wr_valid     = v6_r;
  assign wr_data.pag  = pag6_r;
  assign wr_data.pig  = pig6_r;
  assign wr_data.num2 = num2_6_r;
  assign wr_data.num3 = num3_6_r;
  assign wr_data.d1   = d1_6_r;
  assign wr_data.d1sq = d1sq6_r;
  assign wr_data.sa   = sa6_r;
  assign wr_data.sd   = sd6_r;
  assign wr_data.eneg = eneg6_r;
  assign wr_data.dz   = dz6_r;
  assign wr_data.last = last6_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("front credit count above queue depth");

  a_wr_counted: assert property (@(posedge clk) disable iff (!rst_n)
    wr_valid |-> occ_r != '0)
    else $error("queue write without a counted item");

endmodule

>>> rtl/lpj_back.sv
// lpj_back: four pipelined dividers and the output register, stalled as one.
// Depends on lpj_pkg and lpj_div.
module lpj_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lpj_pkg::work_t q_data,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output lpj_pkg::out_t  out_data
);

  localparam int W    = lpj_pkg::WORD_BITS;
  localparam int N0_W = lpj_pkg::PAG_W;
  localparam int E0_W = lpj_pkg::D1_W + lpj_pkg::SH0;
  localparam int N1_W = lpj_pkg::PIG_W + lpj_pkg::SH1;
  localparam int N2_W = lpj_pkg::NUM2_W + lpj_pkg::SH2;
  localparam int N3_W = lpj_pkg::NUM3_W + lpj_pkg::SH3;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

  logic en;
  logic out_valid_r;
  lpj_pkg::out_t out_data_r;

  // whole back part moves unless a result sits unread
  assign en        = !out_valid_r || out_pop;
  assign q_pop     = en && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  logic [W-1:0] quo0, quo1, quo2, quo3;

  lpj_div #(.NUM_W(N0_W), .DEN_W(E0_W)) u_div_val (
    .clk (clk), .en (en),
    .num (q_data.pag),
    .den (E0_W'(q_data.d1) << lpj_pkg::SH0),
    .neg (q_data.sa),
    .quo (quo0)
  );

  lpj_div #(.NUM_W(N1_W), .DEN_W(lpj_pkg::D1_W)) u_div_amp (
    .clk (clk), .en (en),
    .num (N1_W'(q_data.pig) << lpj_pkg::SH1),
    .den (q_data.d1),
    .neg (1'b0),
    .quo (quo1)
  );

  lpj_div #(.NUM_W(N2_W), .DEN_W(lpj_pkg::D1SQ_W)) u_div_ctr (
    .clk (clk), .en (en),
    .num (N2_W'(q_data.num2) << lpj_pkg::SH2),
    .den (q_data.d1sq),
    .neg (q_data.sa ^ q_data.sd),
    .quo (quo2)
  );

  lpj_div #(.NUM_W(N3_W), .DEN_W(lpj_pkg::D1SQ_W)) u_div_wid (
    .clk (clk), .en (en),
    .num (N3_W'(q_data.num3) << lpj_pkg::SH3),
    .den (q_data.d1sq),
    .neg (q_data.sa == q_data.eneg),
    .quo (quo3)
  );

  // sideband follows the divider stages
  logic sv_r    [0:W];
  logic sdz_r   [0:W];
  logic slast_r [0:W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= W; k++) begin
        sv_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      sv_r[0] <= q_pop;
      for (int k = 1; k <= W; k++) begin
        sv_r[k] <= sv_r[k-1];
      end
      out_valid_r <= sv_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdz_r[0]   <= q_data.dz;
      slast_r[0] <= q_data.last;
      for (int k = 1; k <= W; k++) begin
        sdz_r[k]   <= sdz_r[k-1];
        slast_r[k] <= slast_r[k-1];
      end
      out_data_r.peak_value     <= sdz_r[W] ? MAX_POS : quo0;
      out_data_r.d_amplitude    <= sdz_r[W] ? MAX_POS : quo1;
      out_data_r.d_centre       <= sdz_r[W] ? MAX_POS : quo2;
      out_data_r.d_width        <= sdz_r[W] ? MAX_POS : quo3;
      out_data_r.divide_by_zero <= sdz_r[W];
      out_data_r.last_out       <= slast_r[W];
    end
  end

  a_dz_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.divide_by_zero |->
      out_data_r.peak_value == MAX_POS && out_data_r.d_amplitude == MAX_POS &&
      out_data_r.d_centre == MAX_POS && out_data_r.d_width == MAX_POS)
    else $error("zero denominator result not saturated");

  a_damp_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_data_r.d_amplitude[W-1])
    else $error("amplitude derivative came out negative");

endmodule
